### rtl/core/mcc_pkg.sv
`timescale 1ns / 1ps

package mcc_pkg;

    // default sizes
    localparam int PEDAL_BITS_DEF     = 12;
    localparam int TICK_BITS_DEF      = 16;
    localparam int LOCKOUT_PASSES_DEF = 4;

    // register widths
    localparam int RELEASE_W   = 12;
    localparam int CENTER_W    = 12;
    localparam int DEAD_W      = 11;
    localparam int PWM_W       = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    // register reset values
    localparam logic [RELEASE_W-1:0] RELEASE_DELTA_RST = 12'd204;
    localparam logic [CENTER_W-1:0]  CENTER_CODE_RST   = 12'd2048;
    localparam logic [DEAD_W-1:0]    DEAD_BAND_RST     = 11'd81;
    localparam logic [PWM_W-1:0]     PWM_RELOAD_RST    = 24'd16687215;
    localparam logic [PWM_W-1:0]     FULL_SCALE        = 24'hFFFFFF;
    localparam logic [PWM_W-1:0]     PWM_SPAN_RST      = FULL_SCALE - PWM_RELOAD_RST;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RELEASE_DELTA = 2'd0,
        CFG_CENTER_CODE   = 2'd1,
        CFG_DEAD_BAND     = 2'd2,
        CFG_PWM_RELOAD    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic shape;
        logic scale;
        logic div_step;
        logic span;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } status_t;

endpackage

### rtl/core/mcc_if.sv
`timescale 1ns / 1ps

interface mcc_item_if #(
    parameter int PEDAL_BITS = mcc_pkg::PEDAL_BITS_DEF,
    parameter int TICK_BITS  = mcc_pkg::TICK_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PEDAL_BITS-1:0] pedal_code;
    logic                  cancel_pressed;
    logic                  set_pressed;
    logic                  tick_elapsed;
    logic                  window_end;
    logic [TICK_BITS-1:0]  window_ticks;

    modport source (
        output valid, pedal_code, cancel_pressed, set_pressed, tick_elapsed,
               window_end, window_ticks,
        input  ready
    );
    modport sink (
        input  valid, pedal_code, cancel_pressed, set_pressed, tick_elapsed,
               window_end, window_ticks,
        output ready
    );
endinterface

interface mcc_result_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                direction;
    logic [mcc_pkg::PWM_W-1:0] compare_value;
    logic                      cruise_active;
    logic                      override_release;

    modport source (
        output valid, direction, compare_value, cruise_active, override_release,
        input  ready
    );
    modport sink (
        input  valid, direction, compare_value, cruise_active, override_release,
        output ready
    );
endinterface

### rtl/core/mcc_ctrl.sv
`timescale 1ns / 1ps

module mcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output mcc_pkg::cmd_t    cmd,
    input  mcc_pkg::status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHAPE,
        S_SCALE,
        S_DIVIDE,
        S_SPAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_out;

    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.eval     = (state_reg == S_EVAL);
        cmd.shape    = (state_reg == S_SHAPE);
        cmd.scale    = (state_reg == S_SCALE);
        cmd.div_step = (state_reg == S_DIVIDE) && !status.div_done;
        cmd.span     = (state_reg == S_SPAN);
        cmd.load_out = load_out;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:   state_next = S_SHAPE;
            S_SHAPE:  state_next = S_SCALE;
            S_SCALE:  state_next = status.need_div ? S_DIVIDE : S_SPAN;
            S_DIVIDE:
            begin
                if (status.div_done)
                    state_next = S_SPAN;
            end
            S_SPAN:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("controller took a word without leaving idle");

    a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && !status.div_done) |=> (state_reg == S_DIVIDE))
        else $error("divide left before the quotient was complete");

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == S_FINISH))
        else $error("result overwritten while the previous word was pending");

endmodule

### rtl/core/mcc_dp.sv
`timescale 1ns / 1ps

module mcc_dp #(
    parameter int PEDAL_BITS     = mcc_pkg::PEDAL_BITS_DEF,
    parameter int TICK_BITS      = mcc_pkg::TICK_BITS_DEF,
    parameter int LOCKOUT_PASSES = mcc_pkg::LOCKOUT_PASSES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mcc_pkg::cmd_t                  cmd,
    output mcc_pkg::status_t               status,
    input  logic                           cfg_wr_en,
    input  logic [mcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [PEDAL_BITS-1:0]          pedal_code,
    input  logic                           cancel_pressed,
    input  logic                           set_pressed,
    input  logic                           tick_elapsed,
    input  logic                           window_end,
    input  logic [TICK_BITS-1:0]           window_ticks,
    output logic [1:0]                     direction,
    output logic [mcc_pkg::PWM_W-1:0]      compare_value,
    output logic                           cruise_active,
    output logic                           override_release
);

    localparam int MAG_W  = (PEDAL_BITS > mcc_pkg::CENTER_W) ? PEDAL_BITS : mcc_pkg::CENTER_W;
    localparam int OFF_W  = MAG_W + 1;
    localparam int DUTY_W = MAG_W + 1;
    localparam int SAT_W  = PEDAL_BITS + 1;
    localparam int NUM_W  = DUTY_W + TICK_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int LOCK_W = $clog2(LOCKOUT_PASSES + 1);
    localparam int PROD_W = SAT_W + mcc_pkg::PWM_W;
    localparam logic [SAT_W-1:0] FULL_DUTY = {1'b1, {PEDAL_BITS{1'b0}}};
    localparam logic [LOCK_W-1:0] LOCK_LOAD = LOCK_W'(LOCKOUT_PASSES);

    // configuration
    logic [mcc_pkg::RELEASE_W-1:0] release_reg;
    logic [mcc_pkg::CENTER_W-1:0]  center_reg;
    logic [mcc_pkg::DEAD_W-1:0]    dead_reg;
    logic [mcc_pkg::PWM_W-1:0]     span_reg;

    // loop state
    logic                  cruise_reg, cruise_next;
    logic [PEDAL_BITS-1:0] held_reg, held_next;
    logic [TICK_BITS-1:0]  ref_reg, ref_next;
    logic [TICK_BITS-1:0]  latest_reg, latest_next;
    logic [LOCK_W-1:0]     lockout_reg, lockout_next;

    // captured word
    logic [PEDAL_BITS-1:0] pedal_q;
    logic                  cancel_q, set_q, tick_q, wend_q;
    logic [TICK_BITS-1:0]  wticks_q;

    // working registers
    logic [PEDAL_BITS-1:0] speed_reg;
    logic                  eff_reg, released_reg, cruise_out_reg;
    logic [TICK_BITS-1:0]  op_ref_reg, op_latest_reg;
    mcc_pkg::dir_t         dir_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic                  scale_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [TICK_BITS-1:0]  rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PROD_W-1:0]     prod_reg;

    // result word
    logic [1:0]              out_dir_reg;
    logic [mcc_pkg::PWM_W-1:0] out_cmp_reg;
    logic                    out_cruise_reg, out_rel_reg;

    // evaluation of buttons and release
    logic [MAG_W-1:0]  pedal_m, held_m, dep;
    logic              rel, eff, c_cancel;
    logic [LOCK_W-1:0] lock_mid;

    always_comb
    begin
        pedal_m  = MAG_W'(pedal_q);
        held_m   = MAG_W'(held_reg);
        dep      = (held_m > pedal_m) ? (held_m - pedal_m) : (pedal_m - held_m);
        rel      = cruise_reg && (dep > MAG_W'(release_reg));
        eff      = cruise_reg && !rel;
        c_cancel = eff && !cancel_q;

        cruise_next = c_cancel;
        held_next   = held_reg;
        ref_next    = ref_reg;
        if (set_q && (lockout_reg == '0))
        begin
            cruise_next = !c_cancel;
            if (!c_cancel)
            begin
                held_next = pedal_q;
                ref_next  = latest_reg;
            end
        end
        lock_mid = set_q ? LOCK_LOAD : lockout_reg;

        latest_next  = latest_reg;
        lockout_next = lock_mid;
        if (wend_q)
            latest_next = wticks_q;
        else if (tick_q && (lock_mid != '0))
            lockout_next = lock_mid - LOCK_W'(1);
    end

    // offset, direction and raw duty
    logic [OFF_W-1:0]  off, off_neg;
    logic [MAG_W-1:0]  mag;
    logic              neg, stop;
    logic [DUTY_W-1:0] duty_raw;

    always_comb
    begin
        off      = {1'b0, MAG_W'(speed_reg)} - {1'b0, MAG_W'(center_reg)};
        off_neg  = -off;
        neg      = off[OFF_W-1];
        mag      = neg ? off_neg[MAG_W-1:0] : off[MAG_W-1:0];
        stop     = (mag <= MAG_W'(dead_reg));
        duty_raw = {mag, 1'b0};
    end

    // restoring divide, one quotient bit a step
    logic [TICK_BITS:0]   trial, trial_diff;
    logic                 q_bit;

    always_comb
    begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, op_latest_reg};
        q_bit      = (trial >= {1'b0, op_latest_reg});
    end

    // saturation before the span multiply
    logic [NUM_W-1:0] sat_src;
    logic [SAT_W-1:0] duty_sat;

    always_comb
    begin
        sat_src  = scale_reg ? num_reg : NUM_W'(duty_reg);
        duty_sat = (sat_src > NUM_W'(FULL_DUTY)) ? FULL_DUTY : sat_src[SAT_W-1:0];
    end

    assign status.need_div = scale_reg;
    assign status.div_done = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_reg <= mcc_pkg::RELEASE_DELTA_RST;
            center_reg  <= mcc_pkg::CENTER_CODE_RST;
            dead_reg    <= mcc_pkg::DEAD_BAND_RST;
            span_reg    <= mcc_pkg::PWM_SPAN_RST;
            cruise_reg  <= 1'b0;
            held_reg    <= '0;
            ref_reg     <= '0;
            latest_reg  <= '0;
            lockout_reg <= '0;
            cnt_reg     <= '0;
            scale_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (mcc_pkg::cfg_index_t'(cfg_index))
                    mcc_pkg::CFG_RELEASE_DELTA: release_reg <= cfg_data[mcc_pkg::RELEASE_W-1:0];
                    mcc_pkg::CFG_CENTER_CODE:   center_reg  <= cfg_data[mcc_pkg::CENTER_W-1:0];
                    mcc_pkg::CFG_DEAD_BAND:     dead_reg    <= cfg_data[mcc_pkg::DEAD_W-1:0];
                    mcc_pkg::CFG_PWM_RELOAD:
                        span_reg <= mcc_pkg::FULL_SCALE - cfg_data[mcc_pkg::PWM_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.eval)
            begin
                cruise_reg  <= cruise_next;
                held_reg    <= held_next;
                ref_reg     <= ref_next;
                latest_reg  <= latest_next;
                lockout_reg <= lockout_next;
            end

            if (cmd.shape)
                scale_reg <= eff_reg && !stop && (op_latest_reg != '0);

            if (cmd.scale)
                cnt_reg <= CNT_W'(NUM_W);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pedal_q  <= pedal_code;
            cancel_q <= cancel_pressed;
            set_q    <= set_pressed;
            tick_q   <= tick_elapsed;
            wend_q   <= window_end;
            wticks_q <= window_ticks;
        end

        if (cmd.eval)
        begin
            speed_reg      <= eff ? held_reg : pedal_q;
            eff_reg        <= eff;
            released_reg   <= rel;
            cruise_out_reg <= cruise_next;
            op_ref_reg     <= ref_reg;
            op_latest_reg  <= latest_reg;
        end

        if (cmd.shape)
        begin
            if (stop)
            begin
                dir_reg  <= mcc_pkg::DIR_STOP;
                duty_reg <= '0;
            end
            else
            begin
                dir_reg <= neg ? mcc_pkg::DIR_BACK : mcc_pkg::DIR_FWD;
                if (eff_reg && (op_latest_reg == '0))
                    duty_reg <= DUTY_W'(FULL_DUTY);
                else
                    duty_reg <= duty_raw;
            end
        end

        if (cmd.scale)
        begin
            num_reg <= NUM_W'(duty_reg) * NUM_W'(op_ref_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? trial_diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
        end

        if (cmd.span)
            prod_reg <= PROD_W'(duty_sat) * PROD_W'(span_reg);

        if (cmd.load_out)
        begin
            out_dir_reg    <= dir_reg;
            out_cmp_reg    <= mcc_pkg::FULL_SCALE - prod_reg[PEDAL_BITS +: mcc_pkg::PWM_W];
            out_cruise_reg <= cruise_out_reg;
            out_rel_reg    <= released_reg;
        end
    end

    assign direction        = out_dir_reg;
    assign compare_value    = out_cmp_reg;
    assign cruise_active    = out_cruise_reg;
    assign override_release = out_rel_reg;

    a_lockout_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lockout_reg <= LOCK_LOAD)
        else $error("button lockout above its reload value");

    a_cruise_needs_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cruise_reg) |-> set_q)
        else $error("cruise engaged without a set press");

endmodule

### rtl/core/motor_cruise_control_unit.sv
`timescale 1ns / 1ps
// an accepted word steps through eval, shape, scale, a bit-serial ratio divide (only in
//   cruise with a moving drive and a nonzero tick count), span and finish
// a new word is taken only after the last one leaves finish and the block is idle again
// input is taken only while idle; a finished word waits in the output register
// reset (rst_n low, async): cruise off, setpoint/tick snapshots/lockout zero,
//   configuration back to its defaults, no word pending

module motor_cruise_control_unit #(
    parameter int PEDAL_BITS     = mcc_pkg::PEDAL_BITS_DEF,
    parameter int TICK_BITS      = mcc_pkg::TICK_BITS_DEF,
    parameter int LOCKOUT_PASSES = mcc_pkg::LOCKOUT_PASSES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mcc_item_if.sink                        item,
    mcc_result_if.source                    result,
    input  logic                            cfg_wr_en,
    input  logic [mcc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // command and status between sequencer and datapath
    mcc_pkg::cmd_t    cmd;
    mcc_pkg::status_t status;

    logic in_ready;
    logic out_valid;

    // sequencer: idle -> eval -> shape -> scale -> (divide) -> span -> finish
    mcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: release check, mode update, offset/deadband, ratio divide,
    // pwm span multiply and the result word register
    mcc_dp #(
        .PEDAL_BITS     (PEDAL_BITS),
        .TICK_BITS      (TICK_BITS),
        .LOCKOUT_PASSES (LOCKOUT_PASSES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .pedal_code       (item.pedal_code),
        .cancel_pressed   (item.cancel_pressed),
        .set_pressed      (item.set_pressed),
        .tick_elapsed     (item.tick_elapsed),
        .window_end       (item.window_end),
        .window_ticks     (item.window_ticks),
        .direction        (result.direction),
        .compare_value    (result.compare_value),
        .cruise_active    (result.cruise_active),
        .override_release (result.override_release)
    );

    // handshake outputs
    assign item.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

### tb/motor_cruise_control_unit_tb.sv
`timescale 1ns / 1ps

module motor_cruise_control_unit_tb;

    localparam int PB  = mcc_pkg::PEDAL_BITS_DEF;
    localparam int TB  = mcc_pkg::TICK_BITS_DEF;
    localparam int RW  = mcc_pkg::RELEASE_W;
    localparam int CW  = mcc_pkg::CENTER_W;
    localparam int DW  = mcc_pkg::DEAD_W;
    localparam int PW  = mcc_pkg::PWM_W;
    localparam int CDW = mcc_pkg::CFG_DATA_W;
    localparam int PEDAL_MAX = (1 << PB) - 1;

    // one control-loop pass as offered on the item channel
    typedef struct packed {
        logic [PB-1:0] pedal_code;
        logic          cancel_btn;
        logic          set_btn;
        logic          tick;
        logic          window_end;
        logic [TB-1:0] window_ticks;
    } pass_t;

    // one word on the result channel
    typedef struct packed {
        mcc_pkg::dir_t direction;
        logic [PW-1:0] compare_value;
        logic          cruise_active;
        logic          override_release;
    } drive_word_t;

    logic clk;
    logic rst_n;
    logic                            cfg_wr_en;
    logic [mcc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [CDW-1:0]                  cfg_data;

    mcc_item_if   item_bus ();
    mcc_result_if result_bus ();

    motor_cruise_control_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // controller mirror: configuration and loop state, reset values
    // ------------------------------------------------------------------
    logic [RW-1:0] release_limit = mcc_pkg::RELEASE_DELTA_RST;
    logic [CW-1:0] center_point  = mcc_pkg::CENTER_CODE_RST;
    logic [DW-1:0] dead_zone     = mcc_pkg::DEAD_BAND_RST;
    logic [PW-1:0] reload_value  = mcc_pkg::PWM_RELOAD_RST;

    logic          cruise_held   = 1'b0;
    logic [PB-1:0] setpoint_q    = '0;
    logic [TB-1:0] ref_ticks_q   = '0;
    logic [TB-1:0] last_ticks_q  = '0;
    logic [2:0]    lockout_q     = '0;

    // words predicted at the accept edge, oldest first
    drive_word_t pending_drive_words[$];

    // handshake pacing, in percent
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // long receiver hold-off, counted down by the receiver itself
    int hold_off_cycles = 0;

    // random stimulus shaping
    int walk_pedal = 2048;
    int tick_base  = 1000;

    // bookkeeping
    int mismatch_count = 0;
    int words_checked  = 0;
    int cruise_words   = 0;
    int release_words  = 0;
    int stop_words     = 0;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // slowest legal run is a few ms, this is well beyond it
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: one pass of the cruise loop, updates the mirror state
    // ------------------------------------------------------------------
    function automatic drive_word_t predict_pass(input pass_t p);
        drive_word_t w;
        longint        speed;
        longint        held;
        longint        ped;
        longint        departure;
        longint        offset;
        longint        mag;
        longint        duty;
        longint        span;
        longint        full;
        logic [PW-1:0] cut;
        logic          released;
        full     = longint'(1) << PB;
        ped      = longint'(p.pedal_code);
        held     = longint'(setpoint_q);
        speed    = ped;
        released = 1'b0;

        // pedal override check comes first
        if (cruise_held)
        begin
            departure = (held > ped) ? held - ped : ped - held;
            if (departure > longint'(release_limit))
            begin
                cruise_held = 1'b0;
                released    = 1'b1;
            end
            else
            begin
                speed = held;
            end
        end

        offset = speed - longint'(center_point);
        mag    = (offset < 0) ? -offset : offset;
        if (mag <= longint'(dead_zone))
        begin
            w.direction = mcc_pkg::DIR_STOP;
            duty        = 0;
        end
        else
        begin
            w.direction = (offset < 0) ? mcc_pkg::DIR_BACK : mcc_pkg::DIR_FWD;
            duty        = 2 * mag;
            // speed ratio correction only while cruise holds
            if (cruise_held)
            begin
                if (last_ticks_q == '0)
                    duty = full;
                else
                    duty = (duty * longint'(ref_ticks_q)) / longint'(last_ticks_q);
            end
            if (duty > full)
                duty = full;
        end

        span = longint'(mcc_pkg::FULL_SCALE) - longint'(reload_value);
        cut  = PW'((duty * span) >> PB);
        w.compare_value    = mcc_pkg::FULL_SCALE - cut;
        w.override_release = released;

        // buttons act on the state after the output was formed
        if (p.cancel_btn)
            cruise_held = 1'b0;
        if (p.set_btn)
        begin
            if (lockout_q == '0)
            begin
                if (!cruise_held)
                begin
                    cruise_held = 1'b1;
                    setpoint_q  = p.pedal_code;
                    ref_ticks_q = last_ticks_q;
                end
                else
                begin
                    cruise_held = 1'b0;
                end
            end
            lockout_q = 3'(mcc_pkg::LOCKOUT_PASSES_DEF);
        end
        // window end restarts the tick count, so no lockout decrement then
        if (p.window_end)
            last_ticks_q = p.window_ticks;
        else if (p.tick && lockout_q != '0)
            lockout_q = lockout_q - 3'd1;

        w.cruise_active = cruise_held;
        return w;
    endfunction

    function automatic pass_t make_pass(input int pedal, input bit cancel, input bit set_b,
                                        input bit tick, input bit wend, input int ticks);
        pass_t p;
        p.pedal_code   = PB'(pedal);
        p.cancel_btn   = cancel;
        p.set_btn      = set_b;
        p.tick         = tick;
        p.window_end   = wend;
        p.window_ticks = TB'(ticks);
        return p;
    endfunction

    // random pass: mostly a pedal that wanders near its last spot, so cruise
    // survives for a while, with occasional jumps that force a release
    function automatic pass_t random_pass();
        pass_t p;
        int    roll;
        int    v;
        roll = int'($urandom_range(99));
        if (roll < 70)
            v = walk_pedal + int'($urandom_range(80)) - 40;
        else if (roll < 90)
            v = walk_pedal + int'($urandom_range(600)) - 300;
        else
            v = int'($urandom_range(PEDAL_MAX));
        if (v < 0)
            v = 0;
        if (v > PEDAL_MAX)
            v = PEDAL_MAX;
        walk_pedal   = v;
        p.pedal_code = PB'(v);
        p.set_btn    = ($urandom_range(99) < 7);
        p.cancel_btn = ($urandom_range(99) < 3);
        p.tick       = ($urandom_range(99) < 55);
        p.window_end = ($urandom_range(99) < 15);
        roll = int'($urandom_range(99));
        // encoder counts cluster around a base speed, with odd ones mixed in
        if (roll < 80)
            p.window_ticks = TB'(tick_base + int'($urandom_range(120)));
        else if (roll < 90)
            p.window_ticks = TB'($urandom_range(65535));
        else if (roll < 95)
            p.window_ticks = '0;
        else
            p.window_ticks = '1;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // sender: one word on the item channel, predicted at its accept edge
    // ------------------------------------------------------------------
    task automatic send_pass(input pass_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.valid          = 1'b1;
        item_bus.pedal_code     = p.pedal_code;
        item_bus.cancel_pressed = p.cancel_btn;
        item_bus.set_pressed    = p.set_btn;
        item_bus.tick_elapsed   = p.tick;
        item_bus.window_end     = p.window_end;
        item_bus.window_ticks   = p.window_ticks;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        pending_drive_words.push_back(predict_pass(p));
        @(negedge clk);
    endtask

    // stop offering and wait for the block to drain
    task automatic settle();
        item_bus.valid = 1'b0;
        while (pending_drive_words.size() != 0)
            @(negedge clk);
        // every pass yields a word; the extra wait is only a margin
        repeat (8) @(negedge clk);
    endtask

    // register writes, only called with the block drained
    task automatic write_config(input logic [RW-1:0] rel,
                                input logic [CW-1:0] ctr,
                                input logic [DW-1:0] dz,
                                input logic [PW-1:0] rld);
        cfg_wr_en = 1'b1;
        cfg_index = mcc_pkg::CFG_RELEASE_DELTA;
        cfg_data  = CDW'(rel);
        @(negedge clk);
        cfg_index = mcc_pkg::CFG_CENTER_CODE;
        cfg_data  = CDW'(ctr);
        @(negedge clk);
        cfg_index = mcc_pkg::CFG_DEAD_BAND;
        cfg_data  = CDW'(dz);
        @(negedge clk);
        cfg_index = mcc_pkg::CFG_PWM_RELOAD;
        cfg_data  = CDW'(rld);
        @(negedge clk);
        cfg_wr_en     = 1'b0;
        release_limit = rel;
        center_point  = ctr;
        dead_zone     = dz;
        reload_value  = rld;
    endtask

    task automatic random_config();
        write_config(RW'($urandom_range(600, 20)), CW'($urandom_range(2600, 1500)),
                     DW'($urandom_range(200)), PW'($urandom_range(24'hFFFFFF)));
        tick_base = int'($urandom_range(4000, 1));
    endtask

    task automatic random_run(input int n, input int idle, input int stall);
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        repeat (n) send_pass(random_pass());
    endtask

    // ------------------------------------------------------------------
    // receiver pacing: ready changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_bus.ready = 1'b0;
            hold_off_cycles  = hold_off_cycles - 1;
        end
        else
        begin
            result_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // checker: each accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_word
        drive_word_t got;
        drive_word_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.direction        = mcc_pkg::dir_t'(result_bus.direction);
            got.compare_value    = result_bus.compare_value;
            got.cruise_active    = result_bus.cruise_active;
            got.override_release = result_bus.override_release;
            if (pending_drive_words.size() == 0)
            begin
                $display("%0t: unexpected word dir=%0d cmp=%h cruise=%b rel=%b", $time,
                         got.direction, got.compare_value, got.cruise_active,
                         got.override_release);
                mismatch_count++;
            end
            else
            begin
                want = pending_drive_words.pop_front();
                words_checked++;
                if (want.cruise_active)
                    cruise_words++;
                if (want.override_release)
                    release_words++;
                if (want.direction == mcc_pkg::DIR_STOP)
                    stop_words++;
                if (got.direction !== want.direction)
                begin
                    $display("%0t: direction expected %0d actual %0d", $time,
                             want.direction, got.direction);
                    mismatch_count++;
                end
                if (got.compare_value !== want.compare_value)
                begin
                    $display("%0t: compare_value expected %h actual %h", $time,
                             want.compare_value, got.compare_value);
                    mismatch_count++;
                end
                if (got.cruise_active !== want.cruise_active)
                begin
                    $display("%0t: cruise_active expected %b actual %b", $time,
                             want.cruise_active, got.cruise_active);
                    mismatch_count++;
                end
                if (got.override_release !== want.override_release)
                begin
                    $display("%0t: override_release expected %b actual %b", $time,
                             want.override_release, got.override_release);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked passes at reset configuration
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // standstill, full forward, full backward (exactly full duty)
        send_pass(make_pass(2048, 0, 0, 0, 0, 0));
        send_pass(make_pass(PEDAL_MAX, 0, 0, 0, 0, 0));
        send_pass(make_pass(0, 0, 0, 0, 0, 0));
        // dead band edges on both sides
        send_pass(make_pass(2129, 0, 0, 0, 0, 0));
        send_pass(make_pass(2130, 0, 0, 0, 0, 0));
        send_pass(make_pass(1967, 0, 0, 0, 0, 0));
        send_pass(make_pass(1966, 0, 0, 0, 0, 0));
        // window end together with a tick latches the count
        send_pass(make_pass(3000, 0, 0, 1, 1, 1000));
        // set engages cruise and starts the lockout
        send_pass(make_pass(3000, 0, 1, 0, 0, 0));
        // ratio 1, then window end with tick must not decrement lockout
        send_pass(make_pass(3000, 0, 0, 1, 1, 500));
        // ratio 2, pedal inside release window so setpoint drives
        send_pass(make_pass(3100, 0, 0, 1, 0, 0));
        send_pass(make_pass(3000, 0, 0, 1, 1, 250));
        // ratio 4: duty overflow saturates
        send_pass(make_pass(3000, 0, 0, 1, 0, 0));
        // zero ticks latched, then full duty in cruise
        send_pass(make_pass(2900, 0, 0, 1, 1, 0));
        send_pass(make_pass(2900, 0, 0, 1, 0, 0));
        send_pass(make_pass(3000, 0, 0, 1, 0, 0));
        // departure exactly at the limit holds, one more releases
        send_pass(make_pass(3204, 0, 0, 0, 0, 0));
        send_pass(make_pass(3205, 0, 0, 0, 0, 0));
        // cancel and set together: cancel first, then set engages
        send_pass(make_pass(1000, 1, 1, 0, 1, 800));
        // set held during lockout reloads it, zero reference gives zero duty
        send_pass(make_pass(1000, 0, 1, 1, 0, 0));
        send_pass(make_pass(1000, 0, 0, 1, 0, 0));
        send_pass(make_pass(1000, 0, 0, 1, 0, 0));
        send_pass(make_pass(1000, 0, 0, 1, 0, 0));
        send_pass(make_pass(1000, 0, 0, 1, 0, 0));
        // set with lockout clear toggles cruise off
        send_pass(make_pass(1000, 0, 1, 0, 0, 0));
        // cancel while off, all-ones encoder count
        send_pass(make_pass(PEDAL_MAX, 1, 0, 1, 1, 65535));
        settle();
    endtask

    // register extremes: zero span and full span, zero and max thresholds
    task automatic test_register_extremes();
        write_config('0, '0, '0, '0);
        tick_base = 1;
        random_run(100, 0, 0);
        settle();
        write_config('1, '1, '1, '1);
        tick_base = 3000;
        random_run(100, 0, 0);
        settle();
        write_config('0, '1, '0, '0);
        tick_base = 60000;
        random_run(100, 26, 26);
        settle();
        write_config('1, '0, '1, 24'h800000);
        tick_base = 200;
        random_run(100, 26, 26);
        settle();
    endtask

    task automatic test_idle_free();
        random_config();
        random_run(400, 0, 0);
        settle();
    endtask

    task automatic test_sparse_source();
        random_config();
        random_run(350, 85, 0);
        settle();
    endtask

    task automatic test_stalled_sink();
        random_config();
        random_run(350, 0, 85);
        settle();
    endtask

    task automatic test_mixed_idling();
        random_config();
        random_run(350, 26, 26);
        settle();
    endtask

    // receiver holds off long enough that the block stalls its input,
    // then the sender pauses until every word is back
    task automatic test_back_pressure();
        random_config();
        hold_off_cycles = 400;
        random_run(50, 0, 0);
        item_bus.valid = 1'b0;
        while (pending_drive_words.size() != 0)
            @(negedge clk);
        random_run(40, 26, 26);
        settle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_index               = mcc_pkg::CFG_RELEASE_DELTA;
        cfg_data                = '0;
        item_bus.valid          = 1'b0;
        item_bus.pedal_code     = '0;
        item_bus.cancel_pressed = 1'b0;
        item_bus.set_pressed    = 1'b0;
        item_bus.tick_elapsed   = 1'b0;
        item_bus.window_end     = 1'b0;
        item_bus.window_ticks   = '0;
        result_bus.ready        = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_register_extremes();
        test_idle_free();
        test_back_pressure();
        test_sparse_source();
        test_stalled_sink();
        test_mixed_idling();

        // last word is back, allow the cruise latency before closing
        repeat (50) @(posedge clk);
        $display("checked %0d words: %0d in cruise, %0d pedal releases, %0d stopped",
                 words_checked, cruise_words, release_words, stop_words);
        $display("register extremes and random settings, idle/stall pacing, long hold-off");
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
